// ----- rtl/nfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nfb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ID_FIRST8 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_LAST2  = 1'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [7:0] MAX_PAYLOAD = 8'd240;
    localparam logic [7:0] SOF_BYTE    = 8'hFE;
    localparam logic [7:0] EOF_BYTE    = 8'hEF;
    localparam logic [7:0] LEN_BIAS    = 8'd15;
    localparam logic [7:0] PROTO_BYTE  = 8'h10;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    typedef struct packed {
        logic       opcode;
        logic [7:0] cmd_code;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } nfb_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       run_last;
        logic       order_error;
    } nfb_out_t;

    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_DATA,
        KIND_ERR
    } nfb_kind_t;

    // one queued job: header burst, payload byte, or order error
    typedef struct packed {
        nfb_kind_t  kind;
        logic [7:0] value;
        logic [7:0] length;
        logic [7:0] checksum;
        logic       trailer;
    } nfb_job_t;

endpackage

`default_nettype wire

// ----- rtl/nfb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nfb_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire nfb_pkg::nfb_in_t in_word,
    input  wire logic             q_full,
    output logic                  q_push,
    output nfb_pkg::nfb_job_t     q_job
);
    import nfb_pkg::*;

    logic [7:0] rem_reg, rem_next;
    logic [7:0] sum_reg, sum_next;
    logic       open_reg, open_next;
    logic [7:0] len_sat;
    logic [7:0] sum_add;
    logic [7:0] rem_dec;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        len_sat   = (in_word.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                           : in_word.payload_length;
        sum_add   = sum_reg + in_word.payload_byte;
        rem_dec   = rem_reg - 8'd1;
        rem_next  = rem_reg;
        sum_next  = sum_reg;
        open_next = open_reg;
        q_job     = '{kind: KIND_ERR, value: ZERO_BYTE, length: ZERO_BYTE,
                      checksum: ZERO_BYTE, trailer: 1'b0};
        case (in_word.opcode)
            OP_START:
            begin
                q_job.kind     = KIND_HDR;
                q_job.value    = in_word.cmd_code;
                q_job.length   = len_sat;
                q_job.checksum = in_word.cmd_code;
                q_job.trailer  = (len_sat == 8'd0);
                if (q_push)
                begin
                    sum_next  = in_word.cmd_code;
                    rem_next  = len_sat;
                    open_next = (len_sat != 8'd0);
                end
            end
            OP_DATA:
            begin
                if (open_reg)
                begin
                    q_job.kind     = KIND_DATA;
                    q_job.value    = in_word.payload_byte;
                    q_job.checksum = sum_add;
                    q_job.trailer  = (rem_dec == 8'd0);
                    if (q_push)
                    begin
                        sum_next  = sum_add;
                        rem_next  = rem_dec;
                        open_next = (rem_dec != 8'd0);
                    end
                end
            end
            default:
            begin
                q_job.kind = KIND_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= 8'd0;
            sum_reg  <= 8'd0;
            open_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            sum_reg  <= sum_next;
            open_reg <= open_next;
        end
    end

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (rem_reg != 8'd0))
        else $error("open frame with no payload bytes left");

    a_len_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_job.kind == KIND_HDR) |-> (q_job.length <= MAX_PAYLOAD))
        else $error("header length above limit");

endmodule

`default_nettype wire

// ----- rtl/nfb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nfb_queue #(
    parameter int DEPTH = nfb_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire nfb_pkg::nfb_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output nfb_pkg::nfb_job_t      head_job
);
    import nfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    nfb_job_t        slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- rtl/nfb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nfb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire nfb_pkg::nfb_job_t head_job,
    output logic                   pop,
    input  wire logic [63:0]       id_first8,
    input  wire logic [15:0]       id_last2,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nfb_pkg::nfb_out_t      out_word
);
    import nfb_pkg::*;

    // word positions inside a header burst and a payload burst
    localparam logic [4:0] HDR_SOF     = 5'd0;
    localparam logic [4:0] HDR_LEN     = 5'd1;
    localparam logic [4:0] HDR_PAD0    = 5'd2;
    localparam logic [4:0] HDR_PROTO   = 5'd3;
    localparam logic [4:0] HDR_PAD1    = 5'd4;
    localparam logic [4:0] HDR_STATION = 5'd5;
    localparam logic [4:0] HDR_PAD2    = 5'd15;
    localparam logic [4:0] HDR_CMD     = 5'd16;
    localparam logic [4:0] HDR_SUM     = 5'd17;
    localparam logic [4:0] HDR_EOF     = 5'd18;
    localparam logic [4:0] DAT_BYTE    = 5'd0;
    localparam logic [4:0] DAT_SUM     = 5'd1;
    localparam logic [4:0] DAT_EOF     = 5'd2;
    localparam logic [3:0] STATION_N   = 4'd10;

    logic [4:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    nfb_out_t    out_word_reg, out_word_next;
    logic [4:0]  last_idx;
    logic [4:0]  station_off;
    logic [3:0]  station_sel;
    logic [79:0] station_id;
    logic [7:0]  station_byte;
    nfb_out_t    gen_word;
    logic        load;

    assign station_id  = {id_last2, id_first8};
    assign station_off = idx_reg - HDR_STATION;
    assign station_sel = station_off[3:0];
    assign station_byte = (station_sel < STATION_N) ? station_id[station_sel*8 +: 8]
                                                     : ZERO_BYTE;

    always_comb
    begin
        gen_word = '{frame_byte: ZERO_BYTE, frame_end: 1'b0, run_last: 1'b0,
                     order_error: 1'b0};
        last_idx = 5'd0;
        case (head_job.kind)
            KIND_HDR:
            begin
                last_idx = head_job.trailer ? HDR_EOF : HDR_CMD;
                case (idx_reg)
                    HDR_SOF:   gen_word.frame_byte = SOF_BYTE;
                    HDR_LEN:   gen_word.frame_byte = head_job.length + LEN_BIAS;
                    HDR_PAD0:  gen_word.frame_byte = ZERO_BYTE;
                    HDR_PROTO: gen_word.frame_byte = PROTO_BYTE;
                    HDR_PAD1:  gen_word.frame_byte = ZERO_BYTE;
                    HDR_PAD2:  gen_word.frame_byte = ZERO_BYTE;
                    HDR_CMD:   gen_word.frame_byte = head_job.value;
                    HDR_SUM:   gen_word.frame_byte = head_job.checksum;
                    HDR_EOF:
                    begin
                        gen_word.frame_byte = EOF_BYTE;
                        gen_word.frame_end  = 1'b1;
                    end
                    default:   gen_word.frame_byte = station_byte;
                endcase
            end
            KIND_DATA:
            begin
                last_idx = head_job.trailer ? DAT_EOF : DAT_BYTE;
                case (idx_reg)
                    DAT_BYTE: gen_word.frame_byte = head_job.value;
                    DAT_SUM:  gen_word.frame_byte = head_job.checksum;
                    DAT_EOF:
                    begin
                        gen_word.frame_byte = EOF_BYTE;
                        gen_word.frame_end  = 1'b1;
                    end
                    default:  gen_word.frame_byte = ZERO_BYTE;
                endcase
            end
            KIND_ERR:
            begin
                gen_word.order_error = 1'b1;
            end
            default:
            begin
                gen_word.order_error = 1'b1;
            end
        endcase
        gen_word.run_last = (idx_reg == last_idx);
    end

    assign load = !out_valid_reg || out_ready;
    assign pop  = load && head_valid && (idx_reg == last_idx);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_word_next = gen_word;
                idx_next      = (idx_reg == last_idx) ? 5'd0 : idx_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= HDR_EOF)
        else $error("burst position out of range");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.frame_end) |-> out_word_reg.run_last)
        else $error("frame end word not last of its run");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.order_error) |->
            (out_word_reg.run_last && out_word_reg.frame_byte == ZERO_BYTE))
        else $error("malformed order error word");

endmodule

`default_nettype wire

// ----- rtl/net_frame_builder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------
// in        | in_valid / in_ready        | in_word  (nfb_in_t)
// out       | out_valid / out_ready      | out_word (nfb_out_t)
// cfg       | cfg_wr_en                  | cfg_index, cfg_wdata
//
// A data word produces one output word (three when it is the last payload
// byte); a start word produces 17 output words (19 when the length is zero),
// driven one per cycle by the back end while out_ready is high. An accepted
// input word becomes a queued job before its words reach the output register.
// The job queue between front and back holds QUEUE_DEPTH jobs; in_ready
// drops only when it is full. Output words leave one per cycle, while
// out_ready is high, from a registered output stage. Reset clears frame state,
// queue and output valid; station ID registers reset to zero.

module net_frame_builder #(
    parameter int QUEUE_DEPTH = nfb_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire nfb_pkg::nfb_in_t                  in_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output nfb_pkg::nfb_out_t                      out_word,
    input  wire logic                              cfg_wr_en,
    input  wire logic [nfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nfb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import nfb_pkg::*;

    logic [63:0] id_first8_reg;
    logic [15:0] id_last2_reg;
    logic        q_full;
    logic        q_push;
    nfb_job_t    q_job;
    logic        q_pop;
    logic        head_valid;
    nfb_job_t    head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_first8_reg <= 64'd0;
            id_last2_reg  <= 16'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ID_FIRST8: id_first8_reg <= cfg_wdata[63:0];
                REG_ID_LAST2:  id_last2_reg  <= cfg_wdata[15:0];
                default:       id_last2_reg  <= id_last2_reg;
            endcase
        end
    end

    nfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    nfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    nfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .id_first8  (id_first8_reg),
        .id_last2   (id_last2_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

endmodule

`default_nettype wire
